### rtl/core/cftr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cftr_pkg
// Shared constants and the byte-wise CRC-16 update for the framed telemetry
// receiver.
// ----------------------------------------------------------------------------
package cftr_pkg;

	localparam int MAX_PAYLOAD_DEF = 64;

	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND = 8'h55;
	localparam logic [31:0] AGE_NEVER   = 32'hFFFF_FFFF;

	localparam logic [15:0] TIMEOUT_RST       = 16'd100;
	localparam logic [7:0]  ACCEPT_TYPE_RST   = 8'h30;
	localparam logic [6:0]  ACCEPT_LENGTH_RST = 7'd8;

	// configuration register indexes
	localparam logic [1:0] REG_TIMEOUT       = 2'd0;
	localparam logic [1:0] REG_ACCEPT_TYPE   = 2'd1;
	localparam logic [1:0] REG_ACCEPT_LENGTH = 2'd2;

	localparam int CFG_DATA_W = 16;

	// reflected CRC-16, one byte in, eight shift steps
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### rtl/core/crc16_framed_telemetry_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_framed_telemetry_receiver
// Sync/length framed telemetry parser with CRC-16 check, latched data and age.
// ----------------------------------------------------------------------------
// Each request is either one received UART byte or a millisecond tick. The
// block takes one request per clock cycle unless a stalled result holds the
// input, and returns exactly one result per request, in the cycle after
// acceptance, from an output register; a new request is taken while a result
// waits as long as that result is being taken in the same cycle. The CRC
// byte update and parser step are combinational and sit between the parser
// state registers and the result register. Frames are AA 55, type, length,
// payload, then the CRC low and high bytes; the CRC (reflected 0xA001, init 0)
// covers type, length and payload. A frame with good CRC, matching type and
// matching length latches position, confidence and status from the first four
// payload bytes, clears the age and bumps the frame counter (which skips zero).
// Ticks add to the age, saturating at all ones, which is also its reset value.
// Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module crc16_framed_telemetry_receiver
	import cftr_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// configuration write port
	input  wire logic                  cfg_write,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	// request channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  req_type,
	input  wire logic [7:0]            data_byte,
	input  wire logic [31:0]           tick_ms,

	// result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [15:0]         position,
	output logic [7:0]                 confidence,
	output logic [7:0]                 status_byte,
	output logic [31:0]                age_ms,
	output logic [15:0]                frame_count,
	output logic                       fresh,
	output logic                       frame_accepted
);

	// length and index width follow from the largest payload
	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;

	typedef enum logic [2:0] {
		ST_HUNT    = 3'd0,
		ST_SYNC2   = 3'd1,
		ST_TYPE    = 3'd2,
		ST_LENGTH  = 3'd3,
		ST_PAYLOAD = 3'd4,
		ST_CRC_LO  = 3'd5,
		ST_CRC_HI  = 3'd6
	} parse_state_t;

	// configuration registers
	logic [15:0] timeout_q;
	logic [7:0]  accept_type_q;
	logic [6:0]  accept_length_q;

	// parser state
	parse_state_t     state_q, state_d;
	logic [7:0]       type_q, type_d;
	logic [LEN_W-1:0] length_q, length_d;
	logic [LEN_W-1:0] index_q, index_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       crc_lo_q, crc_lo_d;
	logic [7:0]       head_q [4];
	logic             head_we;

	// latched telemetry
	logic [15:0] pos_q, pos_d;
	logic [7:0]  conf_q, conf_d;
	logic [7:0]  stat_q, stat_d;
	logic [31:0] age_q, age_d;
	logic [15:0] count_q, count_d;
	logic        accepted;

	logic        req_accept;
	logic [32:0] age_sum;
	logic [15:0] crc_next;

	// hold the request only while a result is waiting and not being taken
	assign in_stall   = out_valid & out_stall;
	assign req_accept = in_valid & ~in_stall;

	assign crc_next = crc_feed(crc_q, data_byte);
	assign age_sum  = {1'b0, age_q} + {1'b0, tick_ms};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q       <= TIMEOUT_RST;
			accept_type_q   <= ACCEPT_TYPE_RST;
			accept_length_q <= ACCEPT_LENGTH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TIMEOUT:       timeout_q       <= cfg_data[15:0];
				REG_ACCEPT_TYPE:   accept_type_q   <= cfg_data[7:0];
				REG_ACCEPT_LENGTH: accept_length_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// one parser step per request
	always_comb begin
		state_d  = state_q;
		type_d   = type_q;
		length_d = length_q;
		index_d  = index_q;
		crc_d    = crc_q;
		crc_lo_d = crc_lo_q;
		pos_d    = pos_q;
		conf_d   = conf_q;
		stat_d   = stat_q;
		age_d    = age_q;
		count_d  = count_q;
		accepted = 1'b0;
		head_we  = 1'b0;
		if (!req_type) begin
			case (state_q)
				ST_HUNT: begin
					if (data_byte == SYNC_FIRST) state_d = ST_SYNC2;
				end
				ST_SYNC2: begin
					// a repeated first sync byte stays synced
					if (data_byte == SYNC_SECOND)     state_d = ST_TYPE;
					else if (data_byte == SYNC_FIRST) state_d = ST_SYNC2;
					else                              state_d = ST_HUNT;
				end
				ST_TYPE: begin
					type_d  = data_byte;
					crc_d   = crc_feed(16'h0000, data_byte);
					state_d = ST_LENGTH;
				end
				ST_LENGTH: begin
					length_d = data_byte[LEN_W-1:0];
					index_d  = '0;
					// drop an oversized frame; zero length goes straight to the CRC
					if ({1'b0, data_byte} > 9'(MAX_PAYLOAD)) begin
						state_d = ST_HUNT;
					end else begin
						crc_d   = crc_next;
						state_d = (data_byte != 8'h00) ? ST_PAYLOAD : ST_CRC_LO;
					end
				end
				ST_PAYLOAD: begin
					head_we = (index_q < LEN_W'(4));
					crc_d   = crc_next;
					index_d = index_q + LEN_W'(1);
					if (index_d >= length_q) state_d = ST_CRC_LO;
				end
				ST_CRC_LO: begin
					crc_lo_d = data_byte;
					state_d  = ST_CRC_HI;
				end
				default: begin
					// CRC high byte: check and latch, then hunt again
					if ({data_byte, crc_lo_q} == crc_q && type_q == accept_type_q &&
					    CMP_W'(length_q) == CMP_W'(accept_length_q)) begin
						pos_d    = {head_q[1], head_q[0]};
						conf_d   = head_q[2];
						stat_d   = head_q[3];
						age_d    = '0;
						count_d  = (count_q == 16'hFFFF) ? 16'd1 : count_q + 16'd1;
						accepted = 1'b1;
					end
					state_d = ST_HUNT;
				end
			endcase
		end else if (age_q != AGE_NEVER) begin
			// saturate the age at all ones
			age_d = age_sum[32] ? AGE_NEVER : age_sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_HUNT;
			type_q   <= '0;
			length_q <= '0;
			index_q  <= '0;
			crc_q    <= '0;
			crc_lo_q <= '0;
			pos_q    <= '0;
			conf_q   <= '0;
			stat_q   <= '0;
			age_q    <= AGE_NEVER;
			count_q  <= '0;
		end else if (req_accept) begin
			state_q  <= state_d;
			type_q   <= type_d;
			length_q <= length_d;
			index_q  <= index_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
			pos_q    <= pos_d;
			conf_q   <= conf_d;
			stat_q   <= stat_d;
			age_q    <= age_d;
			count_q  <= count_d;
		end
	end

	// first four payload bytes, no reset
	always_ff @(posedge clk) begin
		if (req_accept && head_we) begin
			head_q[index_q[1:0]] <= data_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (req_accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			position       <= signed'(pos_d);
			confidence     <= conf_d;
			status_byte    <= stat_d;
			age_ms         <= age_d;
			frame_count    <= count_d;
			fresh          <= (age_d <= {16'h0000, timeout_q}) && (stat_d != 8'h00);
			frame_accepted <= accepted;
		end
	end

endmodule
`default_nettype wire

### tb/crc16_framed_telemetry_receiver_test.sv
// ----------------------------------------------------------------------------
// crc16_framed_telemetry_receiver_test
// Drives UART byte and millisecond tick requests into the framed telemetry
// receiver. A local model of the frame parser, CRC and latched data predicts
// every result, which is checked field by field in arrival order. The run
// covers directed frames first, then random traffic under several idle and
// stall patterns and register settings.
// ----------------------------------------------------------------------------
module crc16_framed_telemetry_receiver_test;
	import cftr_pkg::*;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;
	localparam int   CYCLE_LIMIT = 200000;

	// parser phases of the local model
	typedef enum logic [2:0] {
		PH_SYNC1   = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_TYPE    = 3'd2,
		PH_LENGTH  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CRC_LO  = 3'd5,
		PH_CRC_HI  = 3'd6
	} frame_phase_t;

	typedef struct packed {
		logic signed [15:0] position;
		logic [7:0]         confidence;
		logic [7:0]         status;
		logic [31:0]        age;
		logic [15:0]        count;
		logic               fresh;
		logic               accepted;
	} telemetry_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [1:0]            cfg_index = REG_TIMEOUT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  req_type = REQ_BYTE;
	logic [7:0]            data_byte = 8'h00;
	logic [31:0]           tick_ms = 32'h0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [15:0]    position;
	logic [7:0]            confidence;
	logic [7:0]            status_byte;
	logic [31:0]           age_ms;
	logic [15:0]           frame_count;
	logic                  fresh;
	logic                  frame_accepted;

	// run control
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned requests_sent = 0;
	int unsigned failures = 0;
	int unsigned cycle_count = 0;

	// predicted results, oldest first
	telemetry_t expected_telemetry[$];

	// local copy of the registers
	logic [15:0] cfg_timeout = TIMEOUT_RST;
	logic [7:0]  cfg_type    = ACCEPT_TYPE_RST;
	logic [6:0]  cfg_length  = ACCEPT_LENGTH_RST;

	// local copy of the parser and latched data
	frame_phase_t rx_phase = PH_SYNC1;
	logic [7:0]   rx_type = 8'h00;
	logic [7:0]   rx_length = 8'h00;
	logic [6:0]   rx_index = 7'd0;
	logic [15:0]  rx_crc = 16'h0000;
	logic [7:0]   rx_crc_low = 8'h00;
	logic [7:0]   rx_head [4];
	logic [15:0]  held_position = 16'h0000;
	logic [7:0]   held_confidence = 8'h00;
	logic [7:0]   held_status = 8'h00;
	logic [31:0]  held_age = AGE_NEVER;
	logic [15:0]  held_count = 16'h0000;

	crc16_framed_telemetry_receiver DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.data_byte      (data_byte),
		.tick_ms        (tick_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.position       (position),
		.confidence     (confidence),
		.status_byte    (status_byte),
		.age_ms         (age_ms),
		.frame_count    (frame_count),
		.fresh          (fresh),
		.frame_accepted (frame_accepted)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stop a hung run; nothing normal comes near this many cycles.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver side: stall at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Reflected CRC-16 over one byte, LSB first.
	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// Advance the local model by one accepted request and queue the result.
	task automatic predict_telemetry(input logic kind, input logic [7:0] b, input logic [31:0] ms);
		telemetry_t  r;
		logic        hit;
		logic [32:0] sum;
		hit = 1'b0;
		if (kind == REQ_BYTE) begin
			case (rx_phase)
				PH_SYNC1: begin
					if (b == SYNC_FIRST) rx_phase = PH_SYNC2;
				end
				PH_SYNC2: begin
					// a repeated first sync byte keeps the parser synced
					if (b == SYNC_SECOND) rx_phase = PH_TYPE;
					else if (b != SYNC_FIRST) rx_phase = PH_SYNC1;
				end
				PH_TYPE: begin
					rx_type = b;
					rx_crc = crc16_update(16'h0000, b);
					rx_phase = PH_LENGTH;
				end
				PH_LENGTH: begin
					rx_length = b;
					rx_index = 7'd0;
					// drop frames that claim more payload than the buffer holds
					if (b > MAX_PAYLOAD_DEF) begin
						rx_phase = PH_SYNC1;
					end else begin
						rx_crc = crc16_update(rx_crc, b);
						rx_phase = (b != 8'h00) ? PH_PAYLOAD : PH_CRC_LO;
					end
				end
				PH_PAYLOAD: begin
					if (rx_index < 7'd4) rx_head[rx_index[1:0]] = b;
					rx_crc = crc16_update(rx_crc, b);
					rx_index = rx_index + 7'd1;
					if ({1'b0, rx_index} >= rx_length) rx_phase = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					rx_crc_low = b;
					rx_phase = PH_CRC_HI;
				end
				default: begin
					// CRC high byte: latch only a good frame of the wanted type and length
					if ({b, rx_crc_low} == rx_crc && rx_type == cfg_type &&
							rx_length == {1'b0, cfg_length}) begin
						held_position = {rx_head[1], rx_head[0]};
						held_confidence = rx_head[2];
						held_status = rx_head[3];
						held_age = 32'h0;
						held_count = held_count + 16'd1;
						if (held_count == 16'd0) held_count = 16'd1;
						hit = 1'b1;
					end
					rx_phase = PH_SYNC1;
				end
			endcase
		end else if (held_age != AGE_NEVER) begin
			// saturate the age; all ones stays all ones
			sum = {1'b0, held_age} + {1'b0, ms};
			held_age = sum[32] ? AGE_NEVER : sum[31:0];
		end
		r.position = held_position;
		r.confidence = held_confidence;
		r.status = held_status;
		r.age = held_age;
		r.count = held_count;
		r.fresh = (held_age <= {16'h0000, cfg_timeout}) && (held_status != 8'h00);
		r.accepted = hit;
		expected_telemetry.push_back(r);
	endtask

	// Offer one request, hold it until taken, then predict its result.
	task automatic send_request(input logic kind, input logic [7:0] b, input logic [31:0] ms);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		data_byte <= b;
		tick_ms <= ms;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
		predict_telemetry(kind, b, ms);
	endtask

	// Unused fields carry random values so the block must ignore them.
	task automatic send_byte(input logic [7:0] b);
		send_request(REQ_BYTE, b, $urandom);
	endtask

	task automatic send_tick(input logic [31:0] ms);
		send_request(REQ_TICK, 8'($urandom), ms);
	endtask

	// Send one sync-framed packet; head gives payload bytes 0..3, the rest
	// are random. A nonzero crc_flip corrupts the trailer.
	task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flen,
			input logic [31:0] head, input logic [15:0] crc_flip);
		logic [15:0] crc;
		logic [7:0]  b;
		crc = crc16_update(16'h0000, ftype);
		crc = crc16_update(crc, flen);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(ftype);
		send_byte(flen);
		for (int i = 0; i < flen; i++) begin
			b = (i < 4) ? head[8*i +: 8] : 8'($urandom);
			crc = crc16_update(crc, b);
			send_byte(b);
		end
		crc = crc ^ crc_flip;
		send_byte(crc[7:0]);
		send_byte(crc[15:8]);
	endtask

	// Drop valid and wait for every outstanding result, plus a margin.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (expected_telemetry.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] index, input logic [15:0] value);
		wait_for_idle();
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (index)
			REG_TIMEOUT:       cfg_timeout = value;
			REG_ACCEPT_TYPE:   cfg_type = value[7:0];
			REG_ACCEPT_LENGTH: cfg_length = value[6:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [15:0] timeout, input logic [7:0] ftype,
			input logic [6:0] flen);
		write_register(REG_TIMEOUT, timeout);
		write_register(REG_ACCEPT_TYPE, {8'h00, ftype});
		write_register(REG_ACCEPT_LENGTH, {9'h000, flen});
	endtask

	// Random traffic: mostly well-formed frames with random content, plus
	// ticks, line noise, truncated frames and oversized headers.
	task automatic run_random_traffic(input int unsigned count);
		int unsigned goal;
		int unsigned pick;
		logic [7:0]  flen;
		logic [7:0]  ftype;
		logic [15:0] flip;
		goal = requests_sent + count;
		while (requests_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				ftype = ($urandom_range(99) < 80) ? cfg_type : 8'($urandom);
				flen = ($urandom_range(99) < 80) ? {1'b0, cfg_length} : 8'($urandom_range(12));
				flip = ($urandom_range(99) < 85) ? 16'h0000 : 16'($urandom_range(65535, 1));
				if ($urandom_range(99) < 20) send_byte(SYNC_FIRST);
				send_frame(ftype, flen, $urandom, flip);
			end else if (pick < 75) begin
				pick = $urandom_range(99);
				if (pick < 85) send_tick($urandom_range(2 * cfg_timeout + 2));
				else if (pick < 90) send_tick(32'h0);
				else if (pick < 93) send_tick(AGE_NEVER);
				else send_tick($urandom);
			end else if (pick < 85) begin
				repeat ($urandom_range(4, 1)) begin
					pick = $urandom_range(99);
					if (pick < 25) send_byte(SYNC_FIRST);
					else if (pick < 40) send_byte(SYNC_SECOND);
					else send_byte(8'($urandom));
				end
			end else if (pick < 92) begin
				// truncated frame: stop somewhere in the payload, before the trailer
				flen = 8'($urandom_range(12, 1));
				send_byte(SYNC_FIRST);
				send_byte(SYNC_SECOND);
				send_byte(cfg_type);
				send_byte(flen);
				repeat ($urandom_range(flen)) send_byte(8'($urandom));
			end else begin
				send_byte(SYNC_FIRST);
				send_byte(SYNC_SECOND);
				send_byte(8'($urandom));
				send_byte(8'($urandom_range(255, MAX_PAYLOAD_DEF + 1)));
			end
		end
	endtask

	task automatic test_directed_cases();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_register(REG_ACCEPT_LENGTH, 16'd4);
		// tick before any frame: age stays at never
		send_tick(32'd5);
		// repeated sync byte, then a frame with the most negative position,
		// full confidence and a nonzero status
		send_byte(SYNC_FIRST);
		send_frame(ACCEPT_TYPE_RST, 8'd4, 32'h01FF_8000, 16'h0000);
		// largest tick saturates the age and clears fresh
		send_tick(AGE_NEVER);
		// oversized length aborts right after the length byte
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(ACCEPT_TYPE_RST);
		send_byte(8'(MAX_PAYLOAD_DEF + 1));
		// zero length jumps to the CRC; rejected on length
		send_frame(ACCEPT_TYPE_RST, 8'd0, 32'h0, 16'h0000);
		// broken sync pair returns to hunting
		send_byte(SYNC_FIRST);
		send_byte(8'h5A);
	endtask

	task automatic test_clean_stream();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		apply_settings(16'($urandom_range(300, 50)), 8'($urandom), ACCEPT_LENGTH_RST);
		run_random_traffic(205);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 87;
		recv_stall_pct = 0;
		apply_settings(16'h0000, 8'hFF, 7'(MAX_PAYLOAD_DEF));
		run_random_traffic(205);
	endtask

	task automatic test_receiver_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 87;
		apply_settings(16'hFFFF, 8'h00, 7'($urandom_range(16, 4)));
		run_random_traffic(205);
	endtask

	task automatic test_mixed_idling();
		send_idle_pct = 6;
		recv_stall_pct = 6;
		apply_settings(16'($urandom), 8'($urandom), 7'($urandom_range(12, 4)));
		run_random_traffic(205);
	endtask

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endfunction

	// Check each taken result against the oldest prediction.
	always @(posedge clk) begin
		telemetry_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_telemetry.size() == 0) begin
				$error("result taken with no request outstanding");
				failures++;
			end else begin
				want = expected_telemetry.pop_front();
				compare_field("position", 32'(want.position), 32'(position));
				compare_field("confidence", 32'(want.confidence), 32'(confidence));
				compare_field("status_byte", 32'(want.status), 32'(status_byte));
				compare_field("age_ms", want.age, age_ms);
				compare_field("frame_count", 32'(want.count), 32'(frame_count));
				compare_field("fresh", 32'(want.fresh), 32'(fresh));
				compare_field("frame_accepted", 32'(want.accepted), 32'(frame_accepted));
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_clean_stream();
		test_sender_gaps();
		test_receiver_backpressure();
		test_mixed_idling();
		// drain, then leave room for anything late
		wait_for_idle();
		repeat (4) @(posedge clk);
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
